### src/emergency_stop_supervisor_assert.svh
// Assertion macros for the emergency stop supervisor.
`ifndef EMERGENCY_STOP_SUPERVISOR_ASSERT_SVH
`define EMERGENCY_STOP_SUPERVISOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ESTOP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("estop assertion failed");
// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define ESTOP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("estop assertion failed");
`else
`define ESTOP_ASSERT_NOW(lbl, ante, cons)
`define ESTOP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/estop_pkg.sv
// Types, constants and helper functions of the emergency stop supervisor.
package estop_pkg;

    localparam int NUM_AXES   = 3;
    localparam int ADC_BITS   = 12;
    localparam int TICK_W     = 32;
    localparam int TEMP_W     = 8;
    localparam int PERIOD_W   = 16;
    localparam int BEEP_LEN_W = 8;
    localparam int BEEPS_W    = 4;
    localparam int CAUSE_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Fault mask layout
    localparam int BIT_BUTTON  = 0;
    localparam int BIT_LIMIT0  = 1;
    localparam int BIT_DRIVER0 = 1 + NUM_AXES;
    localparam int BIT_UNDER   = 1 + 2 * NUM_AXES;
    localparam int BIT_OVER    = 2 + 2 * NUM_AXES;
    localparam int BIT_TEMP    = 3 + 2 * NUM_AXES;
    localparam int FAULT_W     = 4 + 2 * NUM_AXES;

    // Error LED blink and beep counts
    localparam int BLINK_PERIOD    = 200;
    localparam int BLINK_ON        = 100;
    localparam int BLINK_W         = 8;
    localparam int BEEPS_ON_ENTRY  = 2;
    localparam int BEEPS_ON_BUTTON = 3;
    localparam int BEEPS_MAX       = 15;

    // Register reset values
    localparam logic [ADC_BITS-1:0]   RST_UNDERVOLT = ADC_BITS'(3258);
    localparam logic [ADC_BITS-1:0]   RST_OVERVOLT  = ADC_BITS'(4095);
    localparam logic [TEMP_W-1:0]     RST_OVERTEMP  = TEMP_W'(60);
    localparam logic [PERIOD_W-1:0]   RST_V_PERIOD  = PERIOD_W'(1000);
    localparam logic [PERIOD_W-1:0]   RST_T_PERIOD  = PERIOD_W'(5000);
    localparam logic [BEEP_LEN_W-1:0] RST_BEEP_LEN  = BEEP_LEN_W'(200);
    localparam logic [NUM_AXES-1:0]   RST_LIMIT_POL = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNDERVOLT  = 3'd0,
        CFG_OVERVOLT   = 3'd1,
        CFG_OVERTEMP   = 3'd2,
        CFG_V_PERIOD   = 3'd3,
        CFG_T_PERIOD   = 3'd4,
        CFG_BEEP_LEN   = 3'd5,
        CFG_LIMIT_POL  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [ADC_BITS-1:0]   undervolt_limit;
        logic [ADC_BITS-1:0]   overvolt_limit;
        logic [TEMP_W-1:0]     overtemp_limit;
        logic [PERIOD_W-1:0]   voltage_period;
        logic [PERIOD_W-1:0]   temp_period;
        logic [BEEP_LEN_W-1:0] beep_length;
        logic [NUM_AXES-1:0]   limit_polarity_low;
    } t_cfg;

    typedef struct packed {
        logic                stop_button_level;
        logic [NUM_AXES-1:0] limit_levels;
        logic [NUM_AXES-1:0] driver_fault_levels;
        logic [ADC_BITS-1:0] supply_sample;
        logic [TEMP_W-1:0]   temperature;
        logic                reset_request;
    } t_item;

    typedef struct packed {
        logic               stop_chain_ok;
        logic               ready_led;
        logic               error_led;
        logic               buzzer_on;
        logic [FAULT_W-1:0] fault_mask;
        logic               in_emergency;
        logic               entered_now;
        logic [CAUSE_W-1:0] entry_cause;
        logic               reset_accepted;
    } t_result;

    // Index of the lowest set bit, zero when none is set
    function automatic logic [CAUSE_W-1:0] first_set(input logic [FAULT_W-1:0] v);
        logic [CAUSE_W-1:0] idx;
        idx = '0;
        for (int i = FAULT_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = CAUSE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### src/estop_if.sv
// Handshake channel interfaces: tick samples in, status out, register writes.
interface estop_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   stop_button_level;
    logic [estop_pkg::NUM_AXES-1:0]         limit_levels;
    logic [estop_pkg::NUM_AXES-1:0]         driver_fault_levels;
    logic [estop_pkg::ADC_BITS-1:0]         supply_sample;
    logic signed [estop_pkg::TEMP_W-1:0]    temperature;
    logic                                   reset_request;

    modport source (
        output valid, stop_button_level, limit_levels, driver_fault_levels,
               supply_sample, temperature, reset_request,
        input  ready
    );
    modport sink (
        input  valid, stop_button_level, limit_levels, driver_fault_levels,
               supply_sample, temperature, reset_request,
        output ready
    );
endinterface

interface estop_out_if;
    logic                                valid;
    logic                                ready;
    logic                                stop_chain_ok;
    logic                                ready_led;
    logic                                error_led;
    logic                                buzzer_on;
    logic [estop_pkg::FAULT_W-1:0]       fault_mask;
    logic                                in_emergency;
    logic                                entered_now;
    logic [estop_pkg::CAUSE_W-1:0]       entry_cause;
    logic                                reset_accepted;

    modport source (
        output valid, stop_chain_ok, ready_led, error_led, buzzer_on, fault_mask,
               in_emergency, entered_now, entry_cause, reset_accepted,
        input  ready
    );
    modport sink (
        input  valid, stop_chain_ok, ready_led, error_led, buzzer_on, fault_mask,
               in_emergency, entered_now, entry_cause, reset_accepted,
        output ready
    );
endinterface

interface estop_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [estop_pkg::CFG_IDX_W-1:0]     index;
    logic [estop_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/emergency_stop_supervisor.sv
// Top level of the emergency stop supervisor: request registers and channel handshakes.
`include "emergency_stop_supervisor_assert.svh"

// Takes one tick request per clock cycle, unless the status channel stalls, and
// returns one status result per tick. The result is offered once the request has
// moved from the input register into the result register. The sustained rate is
// one tick per cycle while the status channel is ready, set by the single
// evaluation stage between the two registers. Once both registers are full,
// the input side's ready follows the output side's ready in the same cycle.
// Register writes are always ready; write them only while no tick is in flight.
// No clearing pass runs after reset.
module emergency_stop_supervisor (
    input  logic  i_clk,
    input  logic  i_rst_n,
    estop_in_if.sink    i_in,
    estop_cfg_if.sink   i_cfg,
    estop_out_if.source o_out
);
    import estop_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    t_cfg    cfg;
    t_result result;

    // Move the held request on when the result register is free or its result is being taken
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    estop_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    estop_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.stop_button_level   <= i_in.stop_button_level;
            r_in.limit_levels        <= i_in.limit_levels;
            r_in.driver_fault_levels <= i_in.driver_fault_levels;
            r_in.supply_sample       <= i_in.supply_sample;
            r_in.temperature         <= i_in.temperature;
            r_in.reset_request       <= i_in.reset_request;
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.stop_chain_ok  = r_out.stop_chain_ok;
    assign o_out.ready_led      = r_out.ready_led;
    assign o_out.error_led      = r_out.error_led;
    assign o_out.buzzer_on      = r_out.buzzer_on;
    assign o_out.fault_mask     = r_out.fault_mask;
    assign o_out.in_emergency   = r_out.in_emergency;
    assign o_out.entered_now    = r_out.entered_now;
    assign o_out.entry_cause    = r_out.entry_cause;
    assign o_out.reset_accepted = r_out.reset_accepted;

    // Normal state never shows latched faults
    `ESTOP_ASSERT_NOW(a_normal_clear, o_out.valid && !o_out.in_emergency, o_out.fault_mask == '0)
    // A cause is reported only with an entry
    `ESTOP_ASSERT_NOW(a_cause_entry, o_out.valid && !o_out.entered_now, o_out.entry_cause == '0)
    // Error LED blinks only in emergency
    `ESTOP_ASSERT_NOW(a_led_emerg, o_out.valid && o_out.error_led, o_out.in_emergency)
    // An accepted request is held in the input register next cycle
    `ESTOP_ASSERT_NEXT(a_in_held, i_in.valid && i_in.ready, r_in_valid)

endmodule

### src/estop_cfg_regs.sv
// Configuration register file of the emergency stop supervisor.
module estop_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_we,
    input  logic [estop_pkg::CFG_IDX_W-1:0] i_index,
    input  logic [estop_pkg::CFG_DATA_W-1:0] i_data,
    output estop_pkg::t_cfg                 o_cfg
);
    import estop_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write request into the addressed register
    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (t_cfg_idx'(i_index))
                CFG_UNDERVOLT: n_cfg.undervolt_limit    = i_data[ADC_BITS-1:0];
                CFG_OVERVOLT:  n_cfg.overvolt_limit     = i_data[ADC_BITS-1:0];
                CFG_OVERTEMP:  n_cfg.overtemp_limit     = i_data[TEMP_W-1:0];
                CFG_V_PERIOD:  n_cfg.voltage_period     = i_data[PERIOD_W-1:0];
                CFG_T_PERIOD:  n_cfg.temp_period        = i_data[PERIOD_W-1:0];
                CFG_BEEP_LEN:  n_cfg.beep_length        = i_data[BEEP_LEN_W-1:0];
                CFG_LIMIT_POL: n_cfg.limit_polarity_low = i_data[NUM_AXES-1:0];
                default: ;
            endcase
        end
    end

    // Hold the registers, load reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.undervolt_limit    <= RST_UNDERVOLT;
            r_cfg.overvolt_limit     <= RST_OVERVOLT;
            r_cfg.overtemp_limit     <= RST_OVERTEMP;
            r_cfg.voltage_period     <= RST_V_PERIOD;
            r_cfg.temp_period        <= RST_T_PERIOD;
            r_cfg.beep_length        <= RST_BEEP_LEN;
            r_cfg.limit_polarity_low <= RST_LIMIT_POL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/estop_core.sv
// Supervisor state and the per-tick fault, check, reset and beep logic.
module estop_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  estop_pkg::t_item   i_item,
    input  estop_pkg::t_cfg    i_cfg,
    output estop_pkg::t_result o_result
);
    import estop_pkg::*;

    logic                  r_emerg;
    logic [FAULT_W-1:0]    r_faults;
    logic [TICK_W-1:0]     r_tick;
    logic [TICK_W-1:0]     r_last_v;
    logic [TICK_W-1:0]     r_last_t;
    logic [ADC_BITS-1:0]   r_held;
    logic [BEEPS_W-1:0]    r_beeps;
    logic [BEEP_LEN_W-1:0] r_timer;
    logic                  r_phase;
    logic [BLINK_W-1:0]    r_blink;

    logic                  n_emerg;
    logic [FAULT_W-1:0]    n_faults;
    logic [TICK_W-1:0]     n_tick;
    logic [TICK_W-1:0]     n_last_v;
    logic [TICK_W-1:0]     n_last_t;
    logic [ADC_BITS-1:0]   n_held;
    logic [BEEPS_W-1:0]    n_beeps;
    logic [BEEP_LEN_W-1:0] n_timer;
    logic                  n_phase;
    logic [BLINK_W-1:0]    n_blink;

    logic [NUM_AXES-1:0]   limit_trig;
    logic [NUM_AXES-1:0]   drv_fault;
    logic                  v_due;
    logic                  t_due;
    logic                  under;
    logic                  over;
    logic                  hot;
    logic [FAULT_W-1:0]    raised;
    logic                  entered;
    logic [CAUSE_W-1:0]    cause;
    logic [BEEPS_W:0]      beep_sum;
    logic                  em_chk;
    logic [FAULT_W-1:0]    faults_chk;
    logic                  accepted;
    logic [BEEP_LEN_W-1:0] len;
    logic                  buzz;

    // Evaluate one tick
    always_comb begin
        limit_trig = i_item.limit_levels ^ i_cfg.limit_polarity_low;
        drv_fault  = ~i_item.driver_fault_levels;

        // Periodic supply and temperature checks
        v_due  = (r_tick - r_last_v) > TICK_W'(i_cfg.voltage_period);
        t_due  = (r_tick - r_last_t) > TICK_W'(i_cfg.temp_period);
        n_held = v_due ? i_item.supply_sample : r_held;
        under  = v_due && (i_item.supply_sample < i_cfg.undervolt_limit);
        over   = v_due && (i_item.supply_sample > i_cfg.overvolt_limit);
        hot    = t_due && ($signed(i_item.temperature) > $signed(i_cfg.overtemp_limit));
        n_last_v = v_due ? r_tick : r_last_v;
        n_last_t = t_due ? r_tick : r_last_t;

        // Button counts only from normal state
        raised = {hot, over, under, drv_fault, limit_trig,
                  (!i_item.stop_button_level) && !r_emerg};

        // Normal state has nothing latched: the first raised bit enters
        if (!r_emerg) begin
            em_chk     = |raised;
            faults_chk = raised;
            entered    = |raised;
            cause      = first_set(raised);
        end else begin
            em_chk     = 1'b1;
            faults_chk = r_faults | raised;
            entered    = 1'b0;
            cause      = '0;
        end

        // Queue beeps, saturate
        beep_sum = {1'b0, r_beeps}
                 + (entered ? (BEEPS_W + 1)'(BEEPS_ON_ENTRY) : '0)
                 + ((entered && raised[BIT_BUTTON]) ? (BEEPS_W + 1)'(BEEPS_ON_BUTTON) : '0);
        n_beeps  = (beep_sum > (BEEPS_W + 1)'(BEEPS_MAX)) ? BEEPS_W'(BEEPS_MAX)
                                                          : beep_sum[BEEPS_W-1:0];

        // Judge the reset request after the checks
        n_emerg  = em_chk;
        n_faults = faults_chk;
        accepted = 1'b0;
        if (i_item.reset_request) begin
            if (!em_chk) begin
                accepted = 1'b1;
            end else if (i_item.stop_button_level && (&i_item.driver_fault_levels)
                         && (n_held >= i_cfg.undervolt_limit)
                         && (n_held <= i_cfg.overvolt_limit)) begin
                n_emerg  = 1'b0;
                n_faults = '0;
                accepted = 1'b1;
            end
        end

        // Advance the beep sequencer
        len     = (i_cfg.beep_length == '0) ? BEEP_LEN_W'(1) : i_cfg.beep_length;
        n_phase = r_phase;
        n_timer = r_timer;
        if (!r_phase && (r_timer == '0) && (n_beeps != '0)) begin
            n_beeps = n_beeps - BEEPS_W'(1);
            n_phase = 1'b1;
            n_timer = len;
        end
        buzz = n_phase;
        if (n_timer != '0) begin
            n_timer = n_timer - BEEP_LEN_W'(1);
            if ((n_timer == '0) && n_phase) begin
                n_phase = 1'b0;
                n_timer = (n_beeps != '0) ? len : '0;
            end
        end

        // Tick time and its position in the blink period
        n_tick = r_tick + TICK_W'(1);
        if ((&r_tick) || (r_blink == BLINK_W'(BLINK_PERIOD - 1))) begin
            n_blink = '0;
        end else begin
            n_blink = r_blink + BLINK_W'(1);
        end

        o_result.stop_chain_ok  = !n_emerg;
        o_result.ready_led      = !n_emerg;
        o_result.error_led      = n_emerg && (r_blink < BLINK_W'(BLINK_ON));
        o_result.buzzer_on      = buzz;
        o_result.fault_mask     = n_faults;
        o_result.in_emergency   = n_emerg;
        o_result.entered_now    = entered;
        o_result.entry_cause    = cause;
        o_result.reset_accepted = accepted;
    end

    // Commit the state when a tick moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emerg  <= 1'b0;
            r_faults <= '0;
            r_tick   <= '0;
            r_last_v <= '0;
            r_last_t <= '0;
            r_held   <= '0;
            r_beeps  <= '0;
            r_timer  <= '0;
            r_phase  <= 1'b0;
            r_blink  <= '0;
        end else if (i_advance) begin
            r_emerg  <= n_emerg;
            r_faults <= n_faults;
            r_tick   <= n_tick;
            r_last_v <= n_last_v;
            r_last_t <= n_last_t;
            r_held   <= n_held;
            r_beeps  <= n_beeps;
            r_timer  <= n_timer;
            r_phase  <= n_phase;
            r_blink  <= n_blink;
        end
    end

endmodule

### sim/tb.sv
// Self-checking testbench for the emergency stop supervisor: opening ticks, then random phases.
module tb;
    import estop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_CYCLES     = 10;
    localparam int HOLD_OFF_CYCLES  = 60;
    localparam int N_OPENING        = 24;
    localparam int N_PHASES         = 5;
    localparam int TICKS_PER_PHASE  = 120;
    localparam int PRESSURE_PHASE   = 4;
    localparam int ADC_MAX          = (1 << ADC_BITS) - 1;
    localparam int REPORT_LIMIT     = 10;
    localparam int ITEM_W           = $bits(t_item);

    localparam logic [NUM_AXES-1:0] AX_ALL  = '1;
    localparam logic [ADC_BITS-1:0] SUP_OK  = ADC_BITS'(3500);
    localparam logic [ADC_BITS-1:0] SUP_MAX = '1;
    localparam logic [TEMP_W-1:0]   T_MAX   = TEMP_W'(127);
    localparam logic [TEMP_W-1:0]   T_MIN   = TEMP_W'(-128);

    // Status words that follow directly from reset and the first button press
    localparam t_result STATUS_QUIET =
        '{1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b0};
    localparam t_result STATUS_QUIET_ACK =
        '{1'b1, 1'b1, 1'b0, 1'b0, '0, 1'b0, 1'b0, '0, 1'b1};
    localparam t_result STATUS_BUTTON_ENTRY =
        '{1'b0, 1'b0, 1'b1, 1'b1, FAULT_W'(1) << BIT_BUTTON, 1'b1, 1'b1,
          CAUSE_W'(BIT_BUTTON), 1'b0};

    typedef struct {
        t_item   stim;
        bit      typed;
        t_result want;
    } t_tick_row;

    logic i_clk;
    logic i_rst_n;

    estop_in_if  in_ch();
    estop_out_if out_ch();
    estop_cfg_if cfg_ch();

    emergency_stop_supervisor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Opening ticks, run with short check periods and a one-tick beep
    t_cfg opening_cfg = '{ADC_BITS'(3258), ADC_BITS'(4095), TEMP_W'(60),
                          PERIOD_W'(1), PERIOD_W'(1), BEEP_LEN_W'(1), NUM_AXES'(7)};

    t_tick_row opening_rows [N_OPENING] = '{
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(25), 1'b0}, 1'b1, STATUS_QUIET},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(25), 1'b1}, 1'b1, STATUS_QUIET_ACK},
        '{'{1'b0, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(25), 1'b0}, 1'b1, STATUS_BUTTON_ENTRY},
        '{'{1'b0, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(25), 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(25), 1'b1}, 1'b0, '0},
        '{'{1'b1, 3'b110, AX_ALL, SUP_OK, TEMP_W'(25), 1'b0}, 1'b0, '0},
        '{'{1'b1, 3'b000, 3'b000, SUP_OK, TEMP_W'(25), 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, 3'b000, SUP_OK, TEMP_W'(25), 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(25), 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, '0,     TEMP_W'(25), 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, '0,     TEMP_W'(25), 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_MAX, TEMP_W'(25), 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_MAX, TEMP_W'(25), 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, T_MAX, 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, T_MAX, 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, T_MIN, 1'b1}, 1'b0, '0},
        '{'{1'b0, 3'b000, 3'b000, '0, T_MAX, 1'b0}, 1'b0, '0},
        '{'{1'b0, 3'b000, 3'b000, '0, T_MAX, 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(0), 1'b1}, 1'b0, '0},
        '{'{1'b1, 3'b011, AX_ALL, SUP_OK, TEMP_W'(0), 1'b1}, 1'b0, '0},
        '{'{1'b1, AX_ALL, 3'b101, SUP_OK, TEMP_W'(0), 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(0), 1'b1}, 1'b0, '0},
        '{'{1'b1, 3'b101, AX_ALL, SUP_MAX, TEMP_W'(60), 1'b0}, 1'b0, '0},
        '{'{1'b1, AX_ALL, AX_ALL, SUP_OK, TEMP_W'(61), 1'b1}, 1'b0, '0}
    };

    // Register settings of the random phases, extremes included
    t_cfg phase_cfg [N_PHASES] = '{
        '{ADC_BITS'(0),    ADC_BITS'(4095), T_MIN,        PERIOD_W'(1),
          PERIOD_W'(1),     BEEP_LEN_W'(255), NUM_AXES'(0)},
        '{ADC_BITS'(2000), ADC_BITS'(3000), TEMP_W'(40),  PERIOD_W'(2),
          PERIOD_W'(5),     BEEP_LEN_W'(3),   NUM_AXES'(5)},
        '{ADC_BITS'(4095), ADC_BITS'(0),    T_MAX,        PERIOD_W'(3),
          PERIOD_W'(65535), BEEP_LEN_W'(1),   NUM_AXES'(7)},
        '{ADC_BITS'(1000), ADC_BITS'(3500), TEMP_W'(0),   PERIOD_W'(65535),
          PERIOD_W'(2),     BEEP_LEN_W'(10),  NUM_AXES'(2)},
        '{ADC_BITS'(3258), ADC_BITS'(3700), TEMP_W'(60),  PERIOD_W'(4),
          PERIOD_W'(7),     BEEP_LEN_W'(5),   NUM_AXES'(3)}
    };
    int tx_idle_by_phase  [N_PHASES] = '{0, 83, 0, 35, 0};
    int rx_stall_by_phase [N_PHASES] = '{0, 0, 83, 35, 0};

    // Supervisor state as the predictor sees it
    t_cfg                sup_cfg = '{RST_UNDERVOLT, RST_OVERVOLT, RST_OVERTEMP, RST_V_PERIOD,
                                     RST_T_PERIOD, RST_BEEP_LEN, RST_LIMIT_POL};
    logic                em_mode         = 1'b0;
    logic [FAULT_W-1:0]  fault_latch     = '0;
    logic [TICK_W-1:0]   tick_now        = '0;
    logic [TICK_W-1:0]   last_volt_check = '0;
    logic [TICK_W-1:0]   temp_check_tick = '0;
    logic [ADC_BITS-1:0] held_sample     = '0;
    int                  beeps_queued    = 0;
    int                  beep_count      = 0;
    logic                beep_sounding   = 1'b0;
    logic                entry_seen;
    logic [CAUSE_W-1:0]  entry_bit;

    t_result status_due [$];
    int      ticks_sent      = 0;
    int      results_checked = 0;
    int      error_count     = 0;
    int      tx_idle_pct     = 0;
    int      rx_stall_pct    = 0;
    int      hold_orders     = 0;
    logic    row_typed;
    t_result row_want;

    function automatic void add_beeps(input int n);
        beeps_queued = (beeps_queued + n > BEEPS_MAX) ? BEEPS_MAX : beeps_queued + n;
    endfunction

    function automatic void declare_emergency(input int b);
        em_mode = 1'b1;
        fault_latch[b] = 1'b1;
        if (!entry_seen) begin
            entry_seen = 1'b1;
            entry_bit = CAUSE_W'(b);
        end
        add_beeps(BEEPS_ON_ENTRY);
    endfunction

    // Latch a fault; only a new fault in normal state enters the emergency
    function automatic void latch_fault(input int b);
        if (!fault_latch[b]) begin
            if (!em_mode) begin
                declare_emergency(b);
            end else begin
                fault_latch[b] = 1'b1;
            end
        end
    endfunction

    // Advance the beep sequencer by one tick and return the buzzer level
    function automatic logic sound_buzzer();
        int   len;
        logic buzz;
        len = (sup_cfg.beep_length == 0) ? 1 : int'(sup_cfg.beep_length);
        if (!beep_sounding && beep_count == 0 && beeps_queued > 0) begin
            beeps_queued--;
            beep_sounding = 1'b1;
            beep_count = len;
        end
        buzz = beep_sounding;
        if (beep_count > 0) begin
            beep_count--;
            if (beep_count == 0 && beep_sounding) begin
                beep_sounding = 1'b0;
                beep_count = (beeps_queued != 0) ? len : 0;
            end
        end
        return buzz;
    endfunction

    // Work out the status word of one tick and advance the supervisor state
    function automatic t_result supervise_tick(input t_item it);
        t_result             r;
        logic [TICK_W-1:0]   now;
        logic [NUM_AXES-1:0] trig;
        logic                accepted;
        now = tick_now;
        entry_seen = 1'b0;
        entry_bit = '0;
        accepted = 1'b0;

        if (!it.stop_button_level && !em_mode) begin
            declare_emergency(BIT_BUTTON);
            add_beeps(BEEPS_ON_BUTTON);
        end
        trig = it.limit_levels ^ sup_cfg.limit_polarity_low;
        for (int i = 0; i < NUM_AXES; i++) begin
            if (trig[i]) latch_fault(BIT_LIMIT0 + i);
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            if (!it.driver_fault_levels[i]) latch_fault(BIT_DRIVER0 + i);
        end

        // Periodic supply and temperature checks
        if (now - last_volt_check > TICK_W'(sup_cfg.voltage_period)) begin
            held_sample = it.supply_sample;
            if (held_sample < sup_cfg.undervolt_limit) latch_fault(BIT_UNDER);
            if (held_sample > sup_cfg.overvolt_limit) latch_fault(BIT_OVER);
            last_volt_check = now;
        end
        if (now - temp_check_tick > TICK_W'(sup_cfg.temp_period)) begin
            if ($signed(it.temperature) > $signed(sup_cfg.overtemp_limit)) begin
                latch_fault(BIT_TEMP);
            end
            temp_check_tick = now;
        end

        // Judge the reset request after all checks
        if (it.reset_request) begin
            if (!em_mode) begin
                accepted = 1'b1;
            end else if (it.stop_button_level && it.driver_fault_levels == AX_ALL &&
                         held_sample >= sup_cfg.undervolt_limit &&
                         held_sample <= sup_cfg.overvolt_limit) begin
                em_mode = 1'b0;
                fault_latch = '0;
                accepted = 1'b1;
            end
        end

        r.buzzer_on      = sound_buzzer();
        r.stop_chain_ok  = !em_mode;
        r.ready_led      = !em_mode;
        r.error_led      = em_mode && ((now % BLINK_PERIOD) < BLINK_ON);
        r.fault_mask     = fault_latch;
        r.in_emergency   = em_mode;
        r.entered_now    = entry_seen;
        r.entry_cause    = entry_bit;
        r.reset_accepted = accepted;
        tick_now = now + 1;
        return r;
    endfunction

    // Mostly plausible ticks with random content, one in ten pure noise
    function automatic t_item make_tick();
        t_item it;
        int    lo;
        int    hi;
        int    lim;
        int    pick;
        it = t_item'(ITEM_W'($urandom));
        if ($urandom_range(9) != 0) begin
            it.stop_button_level = ($urandom_range(99) < 4) ? 1'b0 : 1'b1;
            it.limit_levels = sup_cfg.limit_polarity_low;
            if ($urandom_range(99) < 5) begin
                it.limit_levels ^= NUM_AXES'($urandom_range(7, 1));
            end
            it.driver_fault_levels = AX_ALL;
            if ($urandom_range(99) < 5) begin
                it.driver_fault_levels = NUM_AXES'($urandom_range(6));
            end
            lo = int'(sup_cfg.undervolt_limit);
            hi = int'(sup_cfg.overvolt_limit);
            pick = $urandom_range(99);
            if (pick < 8 && lo > 0) begin
                it.supply_sample = ADC_BITS'($urandom_range(lo - 1));
            end else if (pick < 16 && hi < ADC_MAX) begin
                it.supply_sample = ADC_BITS'($urandom_range(ADC_MAX, hi + 1));
            end else if (lo <= hi) begin
                it.supply_sample = ADC_BITS'($urandom_range(hi, lo));
            end
            lim = $signed(sup_cfg.overtemp_limit);
            if ($urandom_range(99) < 8 && lim < 127) begin
                it.temperature = TEMP_W'(lim + 1 + int'($urandom_range(126 - lim)));
            end else begin
                it.temperature = TEMP_W'(lim - int'($urandom_range(lim + 128)));
            end
            it.reset_request = ($urandom_range(99) < 20);
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("status mismatch on %s: expected %0d, got %0d", name, want, got);
            end
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        case (idx)
            CFG_UNDERVOLT: sup_cfg.undervolt_limit    = val[ADC_BITS-1:0];
            CFG_OVERVOLT:  sup_cfg.overvolt_limit     = val[ADC_BITS-1:0];
            CFG_OVERTEMP:  sup_cfg.overtemp_limit     = val[TEMP_W-1:0];
            CFG_V_PERIOD:  sup_cfg.voltage_period     = val[PERIOD_W-1:0];
            CFG_T_PERIOD:  sup_cfg.temp_period        = val[PERIOD_W-1:0];
            CFG_BEEP_LEN:  sup_cfg.beep_length        = val[BEEP_LEN_W-1:0];
            CFG_LIMIT_POL: sup_cfg.limit_polarity_low = val[NUM_AXES-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input t_cfg c);
        write_reg(CFG_UNDERVOLT, CFG_DATA_W'(c.undervolt_limit));
        write_reg(CFG_OVERVOLT,  CFG_DATA_W'(c.overvolt_limit));
        write_reg(CFG_OVERTEMP,  CFG_DATA_W'(c.overtemp_limit));
        write_reg(CFG_V_PERIOD,  CFG_DATA_W'(c.voltage_period));
        write_reg(CFG_T_PERIOD,  CFG_DATA_W'(c.temp_period));
        write_reg(CFG_BEEP_LEN,  CFG_DATA_W'(c.beep_length));
        write_reg(CFG_LIMIT_POL, CFG_DATA_W'(c.limit_polarity_low));
        cfg_ch.valid <= 1'b0;
    endtask

    // Offer one tick request after a random gap and hold it until taken
    task automatic offer_tick(input t_item it, input bit typed, input t_result want);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid               <= 1'b1;
        in_ch.stop_button_level   <= it.stop_button_level;
        in_ch.limit_levels        <= it.limit_levels;
        in_ch.driver_fault_levels <= it.driver_fault_levels;
        in_ch.supply_sample       <= it.supply_sample;
        in_ch.temperature         <= it.temperature;
        in_ch.reset_request       <= it.reset_request;
        row_typed                 <= typed;
        row_want                  <= want;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        ticks_sent++;
    endtask

    // Drop valid and wait until every status word has come back
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (results_checked < ticks_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Stall the status channel at random, with one long hold-off on request
    initial begin : receiver
        int served;
        served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_orders != served) begin
                served++;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) < rx_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    // Predict on every accepted request, check every accepted status word
    always @(posedge i_clk) begin : monitor
        t_item   it;
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                it = '{in_ch.stop_button_level, in_ch.limit_levels, in_ch.driver_fault_levels,
                       in_ch.supply_sample, in_ch.temperature, in_ch.reset_request};
                want = supervise_tick(it);
                if (row_typed) want = row_want;
                status_due.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.stop_chain_ok, out_ch.ready_led, out_ch.error_led,
                        out_ch.buzzer_on, out_ch.fault_mask, out_ch.in_emergency,
                        out_ch.entered_now, out_ch.entry_cause, out_ch.reset_accepted};
                if (status_due.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("status word with no tick pending: %p", got);
                    end
                end else begin
                    want = status_due.pop_front();
                    results_checked++;
                    check_field("stop_chain_ok", 16'(want.stop_chain_ok),
                                16'(got.stop_chain_ok));
                    check_field("ready_led", 16'(want.ready_led), 16'(got.ready_led));
                    check_field("error_led", 16'(want.error_led), 16'(got.error_led));
                    check_field("buzzer_on", 16'(want.buzzer_on), 16'(got.buzzer_on));
                    check_field("fault_mask", 16'(want.fault_mask), 16'(got.fault_mask));
                    check_field("in_emergency", 16'(want.in_emergency),
                                16'(got.in_emergency));
                    check_field("entered_now", 16'(want.entered_now), 16'(got.entered_now));
                    check_field("entry_cause", 16'(want.entry_cause), 16'(got.entry_cause));
                    check_field("reset_accepted", 16'(want.reset_accepted),
                                16'(got.reset_accepted));
                end
            end
        end
    end

    initial begin : stimulus
        i_rst_n                   = 1'b0;
        in_ch.valid               = 1'b0;
        in_ch.stop_button_level   = 1'b1;
        in_ch.limit_levels        = '0;
        in_ch.driver_fault_levels = '0;
        in_ch.supply_sample       = '0;
        in_ch.temperature         = '0;
        in_ch.reset_request       = 1'b0;
        cfg_ch.valid              = 1'b0;
        cfg_ch.index              = '0;
        cfg_ch.data               = '0;
        row_typed                 = 1'b0;
        row_want                  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening ticks: extremes, every fault source but over-voltage, reset paths
        apply_setting(opening_cfg);
        foreach (opening_rows[k]) begin
            offer_tick(opening_rows[k].stim, opening_rows[k].typed, opening_rows[k].want);
        end
        wait_idle();

        // Random phases, each with its own setting and an idling pattern
        for (int p = 0; p < N_PHASES; p++) begin
            apply_setting(phase_cfg[p]);
            tx_idle_pct = tx_idle_by_phase[p];
            rx_stall_pct <= rx_stall_by_phase[p];
            if (p == PRESSURE_PHASE) hold_orders <= hold_orders + 1;
            repeat (TICKS_PER_PHASE) offer_tick(make_tick(), 1'b0, '0);
            wait_idle();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
